@@ sv/vertex_transform_normalize_defines.svh @@
// assertion macros shared by the vertex transform rtl
`ifndef VERTEX_TRANSFORM_NORMALIZE_DEFINES_SVH
`define VERTEX_TRANSFORM_NORMALIZE_DEFINES_SVH
`ifndef ASSERT_OFF
`define VTN_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("vtn assertion failed");
`define VTN_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vtn assertion failed");
`else
`define VTN_ASSERT(label, clk, rst, prop)
`define VTN_ASSERT_IMP(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/vtn_pkg.sv @@
// types and constants of the vertex transform block
package vtn_pkg;

   localparam int CoefBits  = 20;
   localparam int FracShift = 14;
   localparam int QBits     = 15;
   localparam int WideBits  = 80;
   localparam int SqBits    = 48;

   localparam logic [59:0] ROW0_RESET = 60'd16384;
   localparam logic [59:0] ROW1_RESET = 60'd16384 << 20;
   localparam logic [59:0] ROW2_RESET = 60'd16384 << 40;
   localparam logic [SqBits-1:0] NORM_MIN_SQ = SqBits'(3);

   typedef enum logic [2:0] {
      REG_ROW0 = 3'd0,
      REG_ROW1 = 3'd1,
      REG_ROW2 = 3'd2,
      REG_OFFX = 3'd3,
      REG_OFFY = 3'd4,
      REG_OFFZ = 3'd5
   } csr_index_type;

   // payload of one normalization search stage
   typedef struct packed {
      logic [2:0][31:0]          world;
      logic                      pass;
      logic [2:0]                neg;
      logic [2:0][15:0]          rlo;
      logic [SqBits-1:0]         s;
      logic [2:0][WideBits-1:0]  rr;
      logic [2:0][WideBits-1:0]  aa;
      logic [2:0][WideBits-1:0]  bb;
      logic [2:0][QBits-1:0]     q;
   } srch_type;

endpackage

@@ sv/vtn_if.sv @@
// channel interfaces of the vertex transform block
interface vtn_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] pos_x;
   logic signed [23:0] pos_y;
   logic signed [23:0] pos_z;
   logic signed [15:0] nrm_x;
   logic signed [15:0] nrm_y;
   logic signed [15:0] nrm_z;
   modport source(output valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, input ready);
   modport sink(input valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, output ready);
endinterface

interface vtn_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] world_x;
   logic signed [31:0] world_y;
   logic signed [31:0] world_z;
   logic signed [15:0] unit_x;
   logic signed [15:0] unit_y;
   logic signed [15:0] unit_z;
   logic               was_normalized;
   modport source(output valid, world_x, world_y, world_z, unit_x, unit_y, unit_z,
                  was_normalized, input ready);
   modport sink(input valid, world_x, world_y, world_z, unit_x, unit_y, unit_z,
                was_normalized, output ready);
endinterface

interface vtn_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [59:0] wdata;
   modport source(output valid, index, wdata, input ready);
   modport sink(input valid, index, wdata, output ready);
endinterface

@@ sv/vertex_transform_normalize.sv @@
// top level: pipelined vertex transform with normal normalization
//
// channels: req_chan takes one vertex per transfer (Q16.8 position and Q1.14
// normal), rsp_chan returns one transformed vertex per transfer, csr_chan
// writes the matrix rows and origin offsets (csr_chan.ready is always high).
// pipeline: a req transfer passes through these register stages before rsp valid:
//   - 9+9 multiplies, then sums and rounding,
//   - saturation and squaring, then the squared length,
//   - a per-bit search for the 15-bit unit magnitude (one bit a stage),
//   - 1 output register.
// throughput: one vertex per cycle while the output is not stalled; every stage is a register stage.
// reset: pipeline emptied, matrix back to identity, offsets to zero.
// stall: when a result waits and rsp ready is low the whole pipeline holds;
// req ready is low only then, so nothing is lost or repeated.
// configuration should be written only while the pipeline is empty.
`include "vertex_transform_normalize_defines.svh"
module vertex_transform_normalize (
   input logic       clock,
   input logic       reset,
   vtn_req_if.sink   req_chan,
   vtn_rsp_if.source rsp_chan,
   vtn_csr_if.sink   csr_chan
);

   localparam int NS = vtn_pkg::QBits;
   localparam int W  = vtn_pkg::WideBits;
   localparam int SB = vtn_pkg::SqBits;

   // configuration registers
   logic [2:0][59:0] row_ff;
   logic [2:0][31:0] off_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= vtn_pkg::ROW0_RESET;
         row_ff[1] <= vtn_pkg::ROW1_RESET;
         row_ff[2] <= vtn_pkg::ROW2_RESET;
         off_ff    <= '0;
      end else if (csr_chan.valid) begin
         unique case (vtn_pkg::csr_index_type'(csr_chan.index))
            vtn_pkg::REG_ROW0: row_ff[0] <= csr_chan.wdata;
            vtn_pkg::REG_ROW1: row_ff[1] <= csr_chan.wdata;
            vtn_pkg::REG_ROW2: row_ff[2] <= csr_chan.wdata;
            vtn_pkg::REG_OFFX: off_ff[0] <= csr_chan.wdata[31:0];
            vtn_pkg::REG_OFFY: off_ff[1] <= csr_chan.wdata[31:0];
            vtn_pkg::REG_OFFZ: off_ff[2] <= csr_chan.wdata[31:0];
            default: ;
         endcase
      end
   end

   // global advance: every stage moves unless the output is full and stalled
   logic out_v_ff;
   logic adv;
   assign adv           = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // stage 1: products
   logic signed [23:0] pos [3];
   logic signed [15:0] nrm [3];
   logic signed [19:0] coef [3][3];
   assign pos[0] = req_chan.pos_x;
   assign pos[1] = req_chan.pos_y;
   assign pos[2] = req_chan.pos_z;
   assign nrm[0] = req_chan.nrm_x;
   assign nrm[1] = req_chan.nrm_y;
   assign nrm[2] = req_chan.nrm_z;

   logic               s1_v_ff;
   logic signed [43:0] pp_ff [3][3];
   logic signed [35:0] np_ff [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            coef[i][j] = $signed(row_ff[i][j*vtn_pkg::CoefBits +: vtn_pkg::CoefBits]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pp_ff[i][j] <= 44'(pos[j] * coef[i][j]);
               np_ff[i][j] <= 36'(nrm[j] * coef[i][j]);
            end
         end
      end
   end

   // stage 2: row sums, half-up rounding, origin add
   logic               s2_v_ff;
   logic signed [33:0] w_ff [3];
   logic signed [23:0] r_ff [3];
   logic signed [33:0] w_in [3];
   logic signed [23:0] r_in [3];

   always_comb begin
      logic signed [46:0] pt;
      logic signed [38:0] nt;
      for (int i = 0; i < 3; i++) begin
         pt = 47'(pp_ff[i][0]) + 47'(pp_ff[i][1]) + 47'(pp_ff[i][2])
              + 47'sd8192;
         nt = 39'(np_ff[i][0]) + 39'(np_ff[i][1]) + 39'(np_ff[i][2])
              + 39'sd8192;
         w_in[i] = 34'($signed(pt[46:vtn_pkg::FracShift]))
                   + 34'($signed(off_ff[i]));
         r_in[i] = nt[vtn_pkg::FracShift +: 24];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff <= w_in;
         r_ff <= r_in;
      end
   end

   // stage 3: saturation and squares
   logic          s3_v_ff;
   logic [2:0][31:0] ws_ff;
   logic [2:0][31:0] ws_in;
   logic [SB-1:0] sq_ff [3];
   logic [2:0]    neg3_ff;
   logic [2:0][15:0] rlo3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (w_ff[i][33:31] == 3'b000 || w_ff[i][33:31] == 3'b111) begin
            ws_in[i] = w_ff[i][31:0];
         end else if (w_ff[i][33]) begin
            ws_in[i] = 32'h8000_0000;
         end else begin
            ws_in[i] = 32'h7fff_ffff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ws_ff <= ws_in;
         for (int i = 0; i < 3; i++) begin
            // full-width square, evaluated at the squared-length width
            sq_ff[i]   <= SB'(r_ff[i] * r_ff[i]);
            neg3_ff[i] <= r_ff[i][23];
            rlo3_ff[i] <= r_ff[i][15:0];
         end
      end
   end

   // stage 4 and search stages: srch_ff[0] is the squared-length stage,
   // srch_ff[m+1] has decided magnitude bit 14-m
   logic [NS:0]          srch_v_ff;
   vtn_pkg::srch_type    srch_ff [NS+1];
   vtn_pkg::srch_type    srch0_in;

   always_comb begin
      logic [SB-1:0] ssum;
      ssum = sq_ff[0] + sq_ff[1] + sq_ff[2];
      srch0_in.world = ws_ff;
      srch0_in.pass  = ssum < vtn_pkg::NORM_MIN_SQ;
      srch0_in.neg   = neg3_ff;
      srch0_in.rlo   = rlo3_ff;
      srch0_in.s     = ssum;
      for (int i = 0; i < 3; i++) begin
         // target r^2 * 2^30; trial starts at d = -1, so A = S and B = -S
         srch0_in.rr[i] = W'({sq_ff[i], 30'b0});
         srch0_in.aa[i] = W'(ssum);
         srch0_in.bb[i] = W'(-$signed(W'(ssum)));
         srch0_in.q[i]  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         srch_v_ff[0] <= 1'b0;
      end else if (adv) begin
         srch_v_ff[0] <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         srch_ff[0] <= srch0_in;
      end
   end

   // each stage tries setting one bit of q: d' = d + 2^(k+1),
   // d'^2 S = A + B 2^(k+2) + S 2^(2k+2), and keeps it when it stays <= r^2 2^30
   for (genvar m = 0; m < NS; m++) begin : g_srch
      localparam int K = NS - 1 - m;
      vtn_pkg::srch_type nxt;

      always_comb begin
         logic signed [W-1:0] cand;
         logic signed [W-1:0] sw;
         nxt = srch_ff[m];
         sw  = $signed(W'(srch_ff[m].s));
         for (int i = 0; i < 3; i++) begin
            cand = $signed(srch_ff[m].aa[i]) + ($signed(srch_ff[m].bb[i]) <<< (K + 2))
                   + (sw <<< (2 * K + 2));
            if (cand <= $signed(srch_ff[m].rr[i])) begin
               nxt.aa[i]   = cand;
               nxt.bb[i]   = $signed(srch_ff[m].bb[i]) + (sw <<< (K + 1));
               nxt.q[i][K] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            srch_v_ff[m+1] <= 1'b0;
         end else if (adv) begin
            srch_v_ff[m+1] <= srch_v_ff[m];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            srch_ff[m+1] <= nxt;
         end
      end
   end

   // output register: sign restore or pass-through
   logic [2:0][31:0] ow_ff;
   logic [2:0][15:0] ou_ff;
   logic [2:0][15:0] ou_in;
   logic             onrm_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (srch_ff[NS].pass) begin
            ou_in[i] = srch_ff[NS].rlo[i];
         end else if (srch_ff[NS].neg[i]) begin
            ou_in[i] = 16'(-$signed({1'b0, srch_ff[NS].q[i]}));
         end else begin
            ou_in[i] = 16'(srch_ff[NS].q[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= srch_v_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ow_ff   <= srch_ff[NS].world;
         ou_ff   <= ou_in;
         onrm_ff <= !srch_ff[NS].pass;
      end
   end

   assign rsp_chan.valid          = out_v_ff;
   assign rsp_chan.world_x        = ow_ff[0];
   assign rsp_chan.world_y        = ow_ff[1];
   assign rsp_chan.world_z        = ow_ff[2];
   assign rsp_chan.unit_x         = ou_ff[0];
   assign rsp_chan.unit_y         = ou_ff[1];
   assign rsp_chan.unit_z         = ou_ff[2];
   assign rsp_chan.was_normalized = onrm_ff;

   // pass-through normals are tiny: each component is -1, 0 or 1
   `VTN_ASSERT_IMP(a_pass_small, clock, reset, out_v_ff && !onrm_ff,
      (ou_ff[0] == 16'hffff || ou_ff[0] == 16'h0000 || ou_ff[0] == 16'h0001))
   // a normalized component never exceeds one in magnitude
   `VTN_ASSERT_IMP(a_unit_range, clock, reset, out_v_ff && onrm_ff,
      ($signed(ou_ff[1]) <= 16'sd16384 && $signed(ou_ff[1]) >= -16'sd16384))
   // the search never settles above one
   `VTN_ASSERT_IMP(a_q_bound, clock, reset, srch_v_ff[NS] && !srch_ff[NS].pass,
      (srch_ff[NS].q[2] <= 15'd16384))

endmodule

@@ verif/vertex_transform_normalize_test.sv @@
// testbench for the vertex transform block: random vertex stream checked against a local predictor
`timescale 1ns / 1ps
module vertex_transform_normalize_test;

   localparam int WatchdogLimit = 5000;
   localparam int DrainCycles   = 30;   // pipeline depth plus margin
   localparam int MaxWait       = 17;
   localparam int ItemsPerPhase = 250;
   localparam logic [2:0] REG_SPARE6 = 3'd6;
   localparam logic [2:0] REG_SPARE7 = 3'd7;
   localparam logic [19:0] COEF_MAX = 20'h7FFFF;
   localparam logic [19:0] COEF_MIN = 20'h80000;
   localparam logic [19:0] COEF_ONE = 20'd16384;

   typedef struct {
      logic signed [23:0] pos [3];
      logic signed [15:0] nrm [3];
   } vertex_type;

   typedef struct {
      logic signed [31:0] world [3];
      logic signed [15:0] unit [3];
      logic               normalized;
   } world_vertex_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vtn_req_if req_chan ();
   vtn_rsp_if rsp_chan ();
   vtn_csr_if csr_chan ();

   vertex_transform_normalize uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   always #5 clock = ~clock;

   // local copy of the programmed matrix rows and origin
   logic [59:0]        row_reg [3];
   logic signed [31:0] origin_reg [3];

   vertex_type       vertex_queue [$];
   world_vertex_type expected_vertices [$];
   int  error_count = 0;
   int  idle_cycles = 0;
   bit  no_gaps = 1'b0;   // toggled for stretches with no idling

   task automatic report(input string what);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // half-up rounding from Q.22 (or Q.28) down by 14 fraction bits
   function automatic longint round_q14(input longint v);
      return (v + (longint'(1) << (vtn_pkg::FracShift - 1))) >>> vtn_pkg::FracShift;
   endfunction

   // nearest q to r * 2^14 / sqrt(s), ties up, by bisection on squares
   function automatic int unit_magnitude(input longint r, input longint s);
      logic [127:0] rhs, lhs, d;
      int lo, hi, mid;
      rhs = (128'(r) * 128'(r)) << 30;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         d = 128'(2 * mid - 1);
         lhs = d * d * 128'(s);
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic world_vertex_type transform_vertex(input vertex_type v);
      world_vertex_type res;
      longint pa, na, c, w, s, mag;
      longint r [3];
      int q;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         pa = 0;
         na = 0;
         for (int j = 0; j < 3; j++) begin
            c = longint'($signed(row_reg[i][j*vtn_pkg::CoefBits +: vtn_pkg::CoefBits]));
            pa += longint'(v.pos[j]) * c;
            na += longint'(v.nrm[j]) * c;
         end
         w = round_q14(pa) + longint'(origin_reg[i]);
         if (w > 64'sd2147483647) w = 64'sd2147483647;
         if (w < -64'sd2147483648) w = -64'sd2147483648;
         res.world[i] = w[31:0];
         r[i] = round_q14(na);
         s += r[i] * r[i];
      end
      // length above 0.0001 exactly when the Q.28 squared length is 3 or more
      res.normalized = (s >= longint'(vtn_pkg::NORM_MIN_SQ));
      for (int i = 0; i < 3; i++) begin
         if (res.normalized) begin
            mag = (r[i] < 0) ? -r[i] : r[i];
            q = unit_magnitude(mag, s);
            res.unit[i] = (r[i] < 0) ? -16'(q) : 16'(q);
         end else begin
            res.unit[i] = r[i][15:0];
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- driver
   int req_gap = 0;
   int gap_count = 0;
   always @(posedge clock) begin
      vertex_type v;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.pos_x <= '0;
         req_chan.pos_y <= '0;
         req_chan.pos_z <= '0;
         req_chan.nrm_x <= '0;
         req_chan.nrm_y <= '0;
         req_chan.nrm_z <= '0;
      end else begin
         // transfer on the input side: predict its result now
         if (req_chan.valid && req_chan.ready) begin
            v.pos[0] = req_chan.pos_x;
            v.pos[1] = req_chan.pos_y;
            v.pos[2] = req_chan.pos_z;
            v.nrm[0] = req_chan.nrm_x;
            v.nrm[1] = req_chan.nrm_y;
            v.nrm[2] = req_chan.nrm_z;
            expected_vertices.insert(expected_vertices.size(), transform_vertex(v));
            gap_count++;
            if (gap_count % 64 == 0) no_gaps = ~no_gaps;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_chan.valid <= 1'b0;
            end else if (vertex_queue.size() > 0) begin
               v = vertex_queue.pop_front();
               req_chan.pos_x <= v.pos[0];
               req_chan.pos_y <= v.pos[1];
               req_chan.pos_z <= v.pos[2];
               req_chan.nrm_x <= v.nrm[0];
               req_chan.nrm_y <= v.nrm[1];
               req_chan.nrm_z <= v.nrm[2];
               req_chan.valid <= 1'b1;
               req_gap = no_gaps ? 0 : $urandom_range(0, MaxWait);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------- monitor
   int rsp_stall = 0;
   always @(posedge clock) begin
      world_vertex_type e;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_vertices.size() == 0) begin
               report("result transfer with nothing expected");
            end else begin
               e = expected_vertices.pop_front();
               if (rsp_chan.world_x !== e.world[0])
                  report($sformatf("world_x %0d, want %0d", rsp_chan.world_x, e.world[0]));
               if (rsp_chan.world_y !== e.world[1])
                  report($sformatf("world_y %0d, want %0d", rsp_chan.world_y, e.world[1]));
               if (rsp_chan.world_z !== e.world[2])
                  report($sformatf("world_z %0d, want %0d", rsp_chan.world_z, e.world[2]));
               if (rsp_chan.unit_x !== e.unit[0])
                  report($sformatf("unit_x %0d, want %0d", rsp_chan.unit_x, e.unit[0]));
               if (rsp_chan.unit_y !== e.unit[1])
                  report($sformatf("unit_y %0d, want %0d", rsp_chan.unit_y, e.unit[1]));
               if (rsp_chan.unit_z !== e.unit[2])
                  report($sformatf("unit_z %0d, want %0d", rsp_chan.unit_z, e.unit[2]));
               if (rsp_chan.was_normalized !== e.normalized)
                  report($sformatf("was_normalized %0b, want %0b",
                                   rsp_chan.was_normalized, e.normalized));
            end
            rsp_stall = no_gaps ? 0 : $urandom_range(0, MaxWait);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------ register writes
   task automatic write_reg(input logic [2:0] idx, input logic [59:0] data);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.wdata <= data;
      do @(posedge clock); while (!csr_chan.ready);
      // transfer happened at this edge: mirror it
      case (idx)
         vtn_pkg::REG_ROW0: row_reg[0] = data;
         vtn_pkg::REG_ROW1: row_reg[1] = data;
         vtn_pkg::REG_ROW2: row_reg[2] = data;
         vtn_pkg::REG_OFFX: origin_reg[0] = data[31:0];
         vtn_pkg::REG_OFFY: origin_reg[1] = data[31:0];
         vtn_pkg::REG_OFFZ: origin_reg[2] = data[31:0];
         default: ;   // spare indexes are ignored
      endcase
      csr_chan.valid <= 1'b0;
   endtask

   task automatic write_all(input logic [19:0] c [9], input logic [31:0] o [3]);
      write_reg(vtn_pkg::REG_ROW0, {c[2], c[1], c[0]});
      write_reg(vtn_pkg::REG_ROW1, {c[5], c[4], c[3]});
      write_reg(vtn_pkg::REG_ROW2, {c[8], c[7], c[6]});
      write_reg(vtn_pkg::REG_OFFX, 60'(o[0]));
      write_reg(vtn_pkg::REG_OFFY, 60'(o[1]));
      write_reg(vtn_pkg::REG_OFFZ, 60'(o[2]));
   endtask

   // wait for the pipeline to empty before touching the registers
   task automatic wait_idle();
      while (vertex_queue.size() != 0 || req_chan.valid || expected_vertices.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic add_vertex(input logic [23:0] px, py, pz, input logic [15:0] nx, ny, nz);
      vertex_type v;
      v.pos = '{px, py, pz};
      v.nrm = '{nx, ny, nz};
      vertex_queue.insert(vertex_queue.size(), v);
   endtask

   function automatic logic [23:0] rand_pos();
      case ($urandom_range(0, 9))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2, 3: return 24'($signed($urandom_range(0, 2048)) - 1024);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_nrm();
      case ($urandom_range(0, 9))
         0: return 16'($signed($urandom_range(0, 4)) - 2);   // tiny: may pass through
         1: return 16'($urandom);                           // any bit pattern
         2: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   task automatic add_random(input int count);
      for (int k = 0; k < count; k++)
         add_vertex(rand_pos(), rand_pos(), rand_pos(), rand_nrm(), rand_nrm(), rand_nrm());
   endtask

   // --------------------------------------------------------------- stimulus
   initial begin
      logic [19:0] c [9];
      logic [31:0] o [3];
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.wdata = '0;
      row_reg[0] = vtn_pkg::ROW0_RESET;
      row_reg[1] = vtn_pkg::ROW1_RESET;
      row_reg[2] = vtn_pkg::ROW2_RESET;
      origin_reg = '{0, 0, 0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed, reset identity matrix
      add_vertex(24'h7FFFFF, 24'h800000, 24'h000000, 16'sd16384, 16'sd0, 16'sd0);
      add_vertex(24'h800000, 24'h7FFFFF, 24'hFFFFFF, -16'sd16384, 16'sd0, 16'sd0);
      add_vertex(24'h000100, 24'hFFFF00, 24'h000080, 16'sd0, 16'sd0, 16'sd0);   // zero normal
      add_vertex(24'h000001, 24'h000000, 24'h000000, 16'sd1, 16'sd0, 16'sd0);   // tiny passes
      add_vertex(24'h000000, 24'h000001, 24'h000000, 16'sd1, -16'sd1, 16'sd0);  // length sq 2
      add_vertex(24'h000000, 24'h000000, 24'h000001, 16'sd1, 16'sd1, -16'sd1);  // sq 3 normalizes
      add_vertex(24'h123456, 24'h654321, 24'hABCDEF, 16'h8000, 16'h8000, 16'h8000);
      add_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      add_vertex(24'h555555, 24'hAAAAAA, 24'h555555, 16'sd9459, 16'sd9459, 16'sd9459);
      add_vertex(24'h000000, 24'h000000, 24'h000000, 16'sd3, 16'sd4, 16'sd0);
      add_random(ItemsPerPhase);
      wait_idle();

      // extremes: largest coefficients, largest offsets, saturation high
      c = '{default: COEF_MAX};
      o = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
      write_all(c, o);
      add_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'sd16384, 16'sd16384, 16'sd16384);
      add_vertex(24'h800000, 24'h800000, 24'h800000, 16'h8000, 16'h8000, 16'h8000);
      add_random(ItemsPerPhase / 2);
      wait_idle();

      // most negative coefficients and offsets, saturation low
      c = '{default: COEF_MIN};
      o = '{32'h80000000, 32'h80000000, 32'h80000000};
      write_all(c, o);
      add_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'sd1, 16'sd0, 16'sd0);
      add_vertex(24'h800000, 24'h800000, 24'h800000, -16'sd1, 16'sd1, 16'sd1);
      add_random(ItemsPerPhase / 2);
      wait_idle();

      // zero matrix: every normal passes through as zero
      c = '{default: 20'd0};
      o = '{32'($urandom), 32'($urandom), 32'($urandom)};
      write_all(c, o);
      add_random(ItemsPerPhase / 4);
      wait_idle();

      // random rotation-scale matrices around unity, then fully random ones
      for (int ph = 0; ph < 4; ph++) begin
         for (int k = 0; k < 9; k++)
            c[k] = (ph < 2) ? 20'($signed($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE)
                            : 20'($urandom);
         for (int k = 0; k < 3; k++) o[k] = $urandom;
         write_all(c, o);
         // spare indexes must leave everything alone
         write_reg(REG_SPARE6, 60'({$urandom, $urandom}));
         write_reg(REG_SPARE7, 60'({$urandom, $urandom}));
         add_random(ItemsPerPhase);
         wait_idle();
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
